>>> rtl/cse_pkg.sv
// Shared types, constants and helper functions of the C string escape encoder.
// Used by every design module of the encoder (not by cse_checker); depends on nothing else.
package cse_pkg;

	localparam int BYTE_W      = 8;
	localparam int LIMIT_W     = 16;
	localparam int OUT_COUNT_W = 16;
	localparam int SPEC_W      = 64;
	localparam int SCNT_W      = 4;
	localparam int SEQ_MAX     = 4;
	localparam int LEN_W       = 3;
	localparam int ADDR_W      = 5;
	localparam int APB_DATA_W  = 64;
	localparam int OUT_DATA_W  = OUT_COUNT_W + BYTE_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;

	localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5c;
	localparam logic [BYTE_W-1:0] CH_X       = 8'h78;
	localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;
	localparam logic [BYTE_W-1:0] ASCII_TOP  = 8'h7f;

	localparam logic [LEN_W-1:0] LEN_PLAIN = 3'd1;
	localparam logic [LEN_W-1:0] LEN_PAIR  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_HEX   = 3'd4;

	typedef enum logic [1:0] {
		REG_OUT_LIMIT,
		REG_SPECIAL_CHARS,
		REG_SPECIAL_COUNT,
		REG_ESCAPE_HIGH
	} reg_idx_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] out_limit;
		logic [SPEC_W-1:0]  special_chars;
		logic [SCNT_W-1:0]  special_count;
		logic               escape_high;
	} cfg_t;

	// Characters that encode one input byte, first character in entry 0.
	typedef struct packed {
		logic [SEQ_MAX-1:0][BYTE_W-1:0] seq;
		logic [LEN_W-1:0]               len;
	} enc_t;

	// Letter of the short escape form, or zero when the byte has none.
	function automatic logic [BYTE_W-1:0] letter_of(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] l;
		unique case (b)
			8'd0:  l = 8'h30; // '0'
			8'd7:  l = 8'h61; // 'a'
			8'd8:  l = 8'h62; // 'b'
			8'd27: l = 8'h65; // 'e'
			8'd12: l = 8'h66; // 'f'
			8'd10: l = 8'h6e; // 'n'
			8'd13: l = 8'h72; // 'r'
			8'd9:  l = 8'h74; // 't'
			8'd11: l = 8'h76; // 'v'
			8'd92: l = 8'h5c; // backslash
			default: l = CH_NUL;
		endcase
		return l;
	endfunction

	// Lower-case hex digit of a nibble.
	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
		logic [BYTE_W-1:0] d;
		if (n < 4'd10) begin
			d = 8'h30 + {4'h0, n};
		end else begin
			d = 8'h57 + {4'h0, n};
		end
		return d;
	endfunction

endpackage

>>> rtl/cse_encode.sv
// Classifies one byte and builds the character sequence that encodes it.
// Purely combinational; depends on cse_pkg.
module cse_encode #(
	parameter int MAX_SPECIAL = 8
) (
	input  cse_pkg::cfg_t      cfg,
	input  logic [7:0]         in_byte,
	output cse_pkg::enc_t      enc
);
	import cse_pkg::*;

	logic              special;
	logic              needs_escape;
	logic [BYTE_W-1:0] letter;

	always_comb begin
		special = 1'b0;
		for (int i = 0; i < MAX_SPECIAL; i++) begin
			if (i < int'(cfg.special_count) && in_byte == cfg.special_chars[8*i +: 8]) begin
				special = 1'b1;
			end
		end
		// A zero byte never counts as special.
		special = special && (in_byte != CH_NUL);
	end

	assign letter       = letter_of(in_byte);
	assign needs_escape = (in_byte < CTRL_LIMIT) || (in_byte == CH_BSLASH) ||
		(cfg.escape_high && (in_byte > ASCII_TOP));

	always_comb begin
		enc.seq = '0;
		enc.len = LEN_PLAIN;
		if (special) begin
			enc.seq[0] = CH_BSLASH;
			enc.seq[1] = in_byte;
			enc.len    = LEN_PAIR;
		end else if (needs_escape) begin
			enc.seq[0] = CH_BSLASH;
			if (letter != CH_NUL) begin
				enc.seq[1] = letter;
				enc.len    = LEN_PAIR;
			end else begin
				enc.seq[1] = CH_X;
				enc.seq[2] = hex_digit(in_byte[7:4]);
				enc.seq[3] = hex_digit(in_byte[3:0]);
				enc.len    = LEN_HEX;
			end
		end else begin
			enc.seq[0] = in_byte;
		end
	end

endmodule

>>> rtl/cse_expand.sv
// Input register, per-character sequencer with count and limit tracking, and result register.
// Depends on cse_pkg and cse_encode.
module cse_expand #(
	parameter int MAX_SPECIAL = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cse_pkg::cfg_t       cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_byte,
	input  logic                s_last,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_char,
	output logic                m_end,
	output logic [15:0]         m_count
);
	import cse_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   last_s1;
	logic [LEN_W-1:0]       idx_q;
	logic [COUNT_WIDTH-1:0] cw_q;
	logic                   drop_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_char_q;
	logic                   out_end_q;
	logic [OUT_COUNT_W-1:0] out_count_q;

	enc_t             enc;
	logic [CMP_W-1:0] cw_ext, cw_inc, lim_ext, cmax, lim;
	logic             chars_left, emit_char, emit_term, produce, hit_limit, chars_done;
	logic             out_free, advance, item_done, finish;

	cse_encode #(.MAX_SPECIAL(MAX_SPECIAL)) u_encode (
		.cfg     (cfg),
		.in_byte (byte_s1),
		.enc     (enc)
	);

	always_comb begin
		cw_ext     = CMP_W'(cw_q);
		cw_inc     = cw_ext + CMP_W'(1);
		lim_ext    = CMP_W'(cfg.out_limit);
		cmax       = CMP_W'({COUNT_WIDTH{1'b1}});
		lim        = (lim_ext > cmax) ? cmax : lim_ext;
		chars_left = idx_q < enc.len;
		emit_char  = valid_s1 && !drop_q && chars_left && (cw_ext < lim);
		hit_limit  = cw_inc >= lim;
		chars_done = ((idx_q + LEN_W'(1)) == enc.len) || hit_limit;
		emit_term  = valid_s1 && !emit_char && last_s1;
		produce    = emit_char || emit_term;
		out_free   = !out_valid_q || m_tready;
		advance    = valid_s1 && (!produce || out_free);
		item_done  = !emit_char || (chars_done && !last_s1);
		finish     = advance && item_done;
		s_tready   = !valid_s1 || finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (finish) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_byte;
			last_s1 <= s_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			cw_q   <= '0;
			drop_q <= 1'b0;
		end else if (advance) begin
			if (emit_char) begin
				cw_q   <= cw_q + COUNT_WIDTH'(1);
				drop_q <= hit_limit;
				idx_q  <= finish ? '0 : idx_q + LEN_W'(1);
			end else if (last_s1) begin
				cw_q   <= '0;
				drop_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				// Limit already reached before a pending character: start dropping.
				drop_q <= drop_q || chars_left;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce && advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && advance) begin
			out_char_q  <= emit_char ? enc.seq[idx_q[1:0]] : CH_NUL;
			out_end_q   <= emit_term;
			out_count_q <= emit_term ? cw_ext[OUT_COUNT_W-1:0] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_char   = out_char_q;
	assign m_end    = out_end_q;
	assign m_count  = out_count_q;

endmodule

>>> rtl/cse_regs.sv
// APB-style configuration registers of the escape encoder.
// Depends on cse_pkg.
module cse_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [cse_pkg::ADDR_W-1:0]         paddr,
	input  logic [cse_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [cse_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	output cse_pkg::cfg_t                      cfg
);
	import cse_pkg::*;

	reg_idx_t sel;
	cfg_t     cfg_q;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_limit     <= LIMIT_RESET;
			cfg_q.special_chars <= '0;
			cfg_q.special_count <= '0;
			cfg_q.escape_high   <= 1'b0;
		end else if (wr_en) begin
			unique case (sel)
				REG_OUT_LIMIT:     cfg_q.out_limit     <= pwdata[LIMIT_W-1:0];
				REG_SPECIAL_CHARS: cfg_q.special_chars <= pwdata[SPEC_W-1:0];
				REG_SPECIAL_COUNT: cfg_q.special_count <= pwdata[SCNT_W-1:0];
				REG_ESCAPE_HIGH:   cfg_q.escape_high   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_OUT_LIMIT:     prdata = APB_DATA_W'(cfg_q.out_limit);
			REG_SPECIAL_CHARS: prdata = APB_DATA_W'(cfg_q.special_chars);
			REG_SPECIAL_COUNT: prdata = APB_DATA_W'(cfg_q.special_count);
			REG_ESCAPE_HIGH:   prdata = APB_DATA_W'(cfg_q.escape_high);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/c_string_escape_encoder.sv
// Top level of the C string escape encoder: configuration port and stream datapath.
// Depends on cse_pkg, cse_regs, cse_expand (and cse_encode below it).
//
// The encoder turns a byte stream into a C-style escaped character stream. Each
// input word carries one byte in tdata[7:0]; tlast marks the last byte of a
// string. A nonzero byte found among the first special_count entries of
// special_chars comes out as a backslash and the byte itself; control bytes,
// backslash and (with escape_high set) bytes above 0x7f come out as a backslash
// and a letter where a short form exists, else as backslash, x and two lower-case
// hex digits; all other bytes pass unchanged. No more than out_limit characters
// are sent per string; after that, bytes are dropped until tlast. The byte
// marked by tlast is followed by a terminator word with a zero character,
// tlast set and the character count in tdata[23:8]. The result register emits
// one character per cycle while the output is not stalled: a plain byte gives one
// character, a short escape two, a hex escape four, and a terminator one more, so
// plain text streams at one byte per clock while the output is ready, and escapes
// stall the input for their extra characters. A dropped byte that is not last
// produces nothing. An accepted byte waits in the input register, and its characters
// are built combinationally and registered in the result register. A byte is
// taken while a finished character still waits on the output. Registers sit at
// byte addresses 0 (out_limit), 8 (special_chars), 16 (special_count) and 24
// (escape_high); change them only while the block is idle.
module c_string_escape_encoder #(
	parameter int MAX_SPECIAL = 8,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last_in
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_char, [23:8] out_count
	output logic        m_tlast,   // string_end
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import cse_pkg::*;

	cfg_t                   cfg;
	logic [BYTE_W-1:0]      out_char;
	logic [OUT_COUNT_W-1:0] out_count;

	cse_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The sequencer holds one byte at a time and walks its escape sequence,
	// counting characters against the limit.
	cse_expand #(
		.MAX_SPECIAL (MAX_SPECIAL),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_expand (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_byte   (s_tdata),
		.s_last   (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_char   (out_char),
		.m_end    (m_tlast),
		.m_count  (out_count)
	);

	assign m_tdata = {out_count, out_char};

endmodule

>>> rtl/cse_checker.sv
// Port-level checks of the escape encoder, bound to the top level.
// Depends only on the top level's ports.
module cse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        pready
);

	// A stalled output word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// The terminator always carries a zero character.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
		else $error("terminator with nonzero character");

	// The count field is zero on ordinary characters.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[23:8] == 16'h0000)
		else $error("count on a non-terminator word");

	// Two terminators in a row need a count of zero on the second.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast ##1 m_tvalid && m_tlast |-> m_tdata[23:8] == 16'h0000)
		else $error("count not cleared after terminator");

	// The configuration port never waits.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind c_string_escape_encoder cse_checker u_cse_checker (.*);
